@@ rtl/srtn_pkg.sv @@
// Shared constants, command codes and types of the SRTN scheduler.
// Used by srtn_cell and srtn_process_scheduler; depends on nothing.
package srtn_pkg;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int SLOT_W = 4;
  localparam int VAL_W  = 16;
  localparam int TIME_W = 21;
  localparam int SUM_W  = 25;

  // Slot index width inside the chain, wide enough for the largest table
  localparam int IDX_W = 6;

  localparam int SLOTS_DEF = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Best candidate handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] arrival;
    logic [VAL_W-1:0] remaining;
    logic [VAL_W-1:0] init_burst;
  } cand_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic             load;
    logic             clear;
    logic             dec;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] arrival;
    logic [VAL_W-1:0] burst;
  } cell_ctrl_t;

endpackage

@@ rtl/srtn_cell.sv @@
// One process slot of the SRTN scheduler chain: holds the slot and passes the
// best candidate so far to its neighbor each cycle. Depends on srtn_pkg.
module srtn_cell #(
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  srtn_pkg::cell_ctrl_t               ctrl,
  input  logic [srtn_pkg::TIME_W-1:0]        cur_time,
  input  srtn_pkg::cand_t                    best_in,
  output srtn_pkg::cand_t                    best_out,
  output logic                               pending
);

  logic [srtn_pkg::VAL_W-1:0] arr_r;
  logic [srtn_pkg::VAL_W-1:0] rem_r;
  logic [srtn_pkg::VAL_W-1:0] init_r;
  logic                       pending_r;
  srtn_pkg::cand_t            best_r;
  srtn_pkg::cand_t            best_nxt;
  logic                       hit;
  logic                       eligible;
  logic                       better;

  assign hit = (ctrl.idx == srtn_pkg::IDX_W'(IDX));

  // Compare this slot against the candidate from upstream
  always_comb begin
    eligible = pending_r &&
               ({{(srtn_pkg::TIME_W-srtn_pkg::VAL_W){1'b0}}, arr_r} <= cur_time);
    better   = eligible &&
               (!best_in.valid || (rem_r < best_in.remaining) ||
                ((rem_r == best_in.remaining) && (arr_r < best_in.arrival)));
    if (better) begin
      best_nxt.valid      = 1'b1;
      best_nxt.idx        = srtn_pkg::IDX_W'(IDX);
      best_nxt.arrival    = arr_r;
      best_nxt.remaining  = rem_r;
      best_nxt.init_burst = init_r;
    end else begin
      best_nxt = best_in;
    end
  end

  // Slot contents: written by load, counted down by the running tick
  always_ff @(posedge clk) begin
    if (ctrl.load && hit) begin
      arr_r  <= ctrl.arrival;
      rem_r  <= ctrl.burst;
      init_r <= ctrl.burst;
    end else if (ctrl.dec && hit) begin
      rem_r <= rem_r - 1'b1;
    end
  end

  // Pending flag and forwarded candidate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      best_r    <= '0;
    end else begin
      best_r <= best_nxt;
      if (ctrl.clear) begin
        pending_r <= 1'b0;
      end else if (ctrl.load && hit) begin
        pending_r <= (ctrl.burst != '0);
      end else if (ctrl.dec && hit && (rem_r == srtn_pkg::VAL_W'(1))) begin
        pending_r <= 1'b0;
      end
    end
  end

  assign best_out = best_r;
  assign pending  = pending_r;

endmodule

@@ rtl/srtn_process_scheduler.sv @@
// Top level of the shortest-remaining-time-next scheduler: control FSM,
// counters, result register and the chain of srtn_cell. Depends on srtn_pkg.
//
//   channel | ports                                             | dir
//   in      | in_valid in_ready in_command in_slot              | sink
//           | in_arrival_time in_burst_time                     |
//   out     | out_valid out_ready out_current_time ...          | source
//
// A pending-slot tick runs S_SCAN, S_UPDATE and S_EMIT: the candidate
// walks the chain one cell per cycle in S_SCAN, S_UPDATE applies it and
// S_EMIT loads the result register. Load, clear and empty ticks go from
// S_IDLE to S_EMIT. One item is in work at a time; a full result register
// stalls the item until out_ready frees it. Reset clears pending flags,
// counters and handshake state; slot contents are undefined until loaded.
module srtn_process_scheduler #(
  parameter int SLOTS = srtn_pkg::SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [srtn_pkg::CMD_W-1:0]         in_command,
  input  logic [srtn_pkg::SLOT_W-1:0]        in_slot,
  input  logic [srtn_pkg::VAL_W-1:0]         in_arrival_time,
  input  logic [srtn_pkg::VAL_W-1:0]         in_burst_time,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [srtn_pkg::TIME_W-1:0]        out_current_time,
  output logic [srtn_pkg::SLOT_W-1:0]        out_running_slot,
  output logic                               out_idle,
  output logic                               out_finished_now,
  output logic                               out_all_done,
  output logic [srtn_pkg::TIME_W-1:0]        out_idle_total,
  output logic [srtn_pkg::SUM_W-1:0]         out_total_turnaround,
  output logic [srtn_pkg::SUM_W-1:0]         out_total_waiting
);

  localparam int CNT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW = srtn_pkg::TIME_W;
  localparam int SW = srtn_pkg::SUM_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPDATE, S_EMIT} state_t;

  state_t                 state_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [TW-1:0]          time_r;
  logic [TW-1:0]          idle_cnt_r;
  logic [SW-1:0]          turn_r;
  logic [SW-1:0]          wait_r;
  logic [srtn_pkg::SLOT_W-1:0] run_r;
  logic                   idle_r;
  logic                   fin_r;

  logic                   out_valid_r;
  logic [TW-1:0]          out_time_r;
  logic [srtn_pkg::SLOT_W-1:0] out_run_r;
  logic                   out_idle_r;
  logic                   out_fin_r;
  logic                   out_done_r;
  logic [TW-1:0]          out_idle_tot_r;
  logic [SW-1:0]          out_turn_r;
  logic [SW-1:0]          out_wait_r;

  srtn_pkg::cell_ctrl_t   ctrl;
  srtn_pkg::cand_t        chain [SLOTS+1];
  srtn_pkg::cand_t        best;
  logic [SLOTS-1:0]       pending_vec;
  logic                   accept;
  logic                   load_ok;
  logic                   any_pending;

  logic [TW-1:0]          time_nxt;
  logic [TW-1:0]          idle_cnt_nxt;
  logic [TW-1:0]          ta;
  logic [TW-1:0]          init_ext;
  logic [TW-1:0]          wt;
  logic [SW:0]            turn_sum;
  logic [SW:0]            wait_sum;
  logic [SW-1:0]          turn_nxt;
  logic [SW-1:0]          wait_nxt;
  logic                   fin_nxt;

  assign in_ready    = (state_r == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign any_pending = |pending_vec;
  assign best        = chain[SLOTS];
  assign load_ok     = ((srtn_pkg::IDX_W+1)'(in_slot) < (srtn_pkg::IDX_W+1)'(SLOTS));

  // Broadcast load, clear and decrement to the cells
  always_comb begin
    ctrl.load    = accept && (in_command == srtn_pkg::CMD_LOAD) && load_ok;
    ctrl.clear   = accept && (in_command == srtn_pkg::CMD_CLEAR);
    ctrl.dec     = (state_r == S_UPDATE) && best.valid;
    ctrl.idx     = ctrl.dec ? best.idx : srtn_pkg::IDX_W'(in_slot);
    ctrl.arrival = in_arrival_time;
    ctrl.burst   = in_burst_time;
  end

  // Cell chain: the best candidate advances one cell per cycle
  assign chain[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    srtn_cell #(
      .IDX (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .cur_time (time_r),
      .best_in  (chain[g]),
      .best_out (chain[g+1]),
      .pending  (pending_vec[g])
    );
  end

  // Tick update arithmetic: saturating time, turnaround and waiting sums
  always_comb begin
    time_nxt     = (time_r == srtn_pkg::TIME_MAX) ? time_r : time_r + 1'b1;
    idle_cnt_nxt = (idle_cnt_r == srtn_pkg::TIME_MAX) ? idle_cnt_r : idle_cnt_r + 1'b1;
    ta           = time_nxt - {{(TW-srtn_pkg::VAL_W){1'b0}}, best.arrival};
    init_ext     = {{(TW-srtn_pkg::VAL_W){1'b0}}, best.init_burst};
    wt           = (ta >= init_ext) ? ta - init_ext : '0;
    turn_sum     = {1'b0, turn_r} + (SW+1)'(ta);
    wait_sum     = {1'b0, wait_r} + (SW+1)'(wt);
    turn_nxt     = turn_sum[SW] ? srtn_pkg::SUM_MAX : turn_sum[SW-1:0];
    wait_nxt     = wait_sum[SW] ? srtn_pkg::SUM_MAX : wait_sum[SW-1:0];
    fin_nxt      = best.valid && (best.remaining == srtn_pkg::VAL_W'(1));
  end

  // Control FSM, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      cnt_r          <= '0;
      time_r         <= '0;
      idle_cnt_r     <= '0;
      turn_r         <= '0;
      wait_r         <= '0;
      run_r          <= '0;
      idle_r         <= 1'b0;
      fin_r          <= 1'b0;
      out_valid_r    <= 1'b0;
      out_time_r     <= '0;
      out_run_r      <= '0;
      out_idle_r     <= 1'b0;
      out_fin_r      <= 1'b0;
      out_done_r     <= 1'b0;
      out_idle_tot_r <= '0;
      out_turn_r     <= '0;
      out_wait_r     <= '0;
    end else begin
      // drop the result beat once taken, unless a new one replaces it
      if (out_valid_r && out_ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            run_r  <= '0;
            idle_r <= 1'b0;
            fin_r  <= 1'b0;
            cnt_r  <= '0;
            if (in_command == srtn_pkg::CMD_CLEAR) begin
              time_r     <= '0;
              idle_cnt_r <= '0;
              turn_r     <= '0;
              wait_r     <= '0;
            end
            if ((in_command == srtn_pkg::CMD_TICK) && any_pending) begin
              state_r <= S_SCAN;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_SCAN: begin
          // wait for the candidate to reach the end of the chain
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(SLOTS-1)) begin
            state_r <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          time_r <= time_nxt;
          if (!best.valid) begin
            idle_r     <= 1'b1;
            idle_cnt_r <= idle_cnt_nxt;
          end else begin
            run_r <= srtn_pkg::SLOT_W'(best.idx);
            fin_r <= fin_nxt;
            if (fin_nxt) begin
              turn_r <= turn_nxt;
              wait_r <= wait_nxt;
            end
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          // hold until the result register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r    <= 1'b1;
            out_time_r     <= time_r;
            out_run_r      <= run_r;
            out_idle_r     <= idle_r;
            out_fin_r      <= fin_r;
            out_done_r     <= !any_pending;
            out_idle_tot_r <= idle_cnt_r;
            out_turn_r     <= turn_r;
            out_wait_r     <= wait_r;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_current_time     = out_time_r;
  assign out_running_slot     = out_run_r;
  assign out_idle             = out_idle_r;
  assign out_finished_now     = out_fin_r;
  assign out_all_done         = out_done_r;
  assign out_idle_total       = out_idle_tot_r;
  assign out_total_turnaround = out_turn_r;
  assign out_total_waiting    = out_wait_r;

  // An idle tick never reports a finish
  a_idle_no_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_idle_r && out_fin_r))
    else $error("idle and finished_now both set");

  // Idle ticks never outnumber elapsed ticks
  a_idle_le_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_idle_tot_r <= out_time_r))
    else $error("idle_total exceeds current_time");

  // The chosen slot is still pending when it is run
  a_best_pending: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_UPDATE) && best.valid) |->
      (|(pending_vec & (SLOTS'(1) << best.idx))))
    else $error("selected slot is not pending");

endmodule

@@ bench/srtn_process_scheduler_tb.sv @@
// Self-checking testbench for srtn_process_scheduler: drives load, tick and clear beats,
// predicts every result beat from a mirror of the slot table and compares field by field.
// Depends on srtn_pkg and the scheduler RTL only.
module srtn_process_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                 CMD_W       = srtn_pkg::CMD_W;
  localparam int                 SLOT_W      = srtn_pkg::SLOT_W;
  localparam int                 VAL_W       = srtn_pkg::VAL_W;
  localparam int                 TIME_W      = srtn_pkg::TIME_W;
  localparam int                 SUM_W       = srtn_pkg::SUM_W;
  localparam logic [TIME_W-1:0]  TIME_MAX    = srtn_pkg::TIME_MAX;
  localparam logic [SUM_W-1:0]   SUM_MAX     = srtn_pkg::SUM_MAX;
  localparam logic [CMD_W-1:0]   CMD_LOAD    = srtn_pkg::CMD_LOAD;
  localparam logic [CMD_W-1:0]   CMD_TICK    = srtn_pkg::CMD_TICK;
  localparam logic [CMD_W-1:0]   CMD_CLEAR   = srtn_pkg::CMD_CLEAR;

  localparam int                 NSLOT       = srtn_pkg::SLOTS_DEF;
  localparam int                 STALL_LIMIT = 2000;
  localparam int                 IDLE_PCT    = 32;
  localparam int                 REACH_AHEAD = 40;
  localparam logic [CMD_W-1:0]   CMD_UNUSED  = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] cur_time;
    logic [SLOT_W-1:0] run_slot;
    logic              idle;
    logic              fin;
    logic              done;
    logic [TIME_W-1:0] idle_tot;
    logic [SUM_W-1:0]  ta_tot;
    logic [SUM_W-1:0]  wt_tot;
  } sched_beat_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    in_command;
  logic [SLOT_W-1:0]   in_slot;
  logic [VAL_W-1:0]    in_arrival_time;
  logic [VAL_W-1:0]    in_burst_time;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [TIME_W-1:0]   out_current_time;
  logic [SLOT_W-1:0]   out_running_slot;
  logic                out_idle;
  logic                out_finished_now;
  logic                out_all_done;
  logic [TIME_W-1:0]   out_idle_total;
  logic [SUM_W-1:0]    out_total_turnaround;
  logic [SUM_W-1:0]    out_total_waiting;

  // Mirror of the scheduler state
  logic [VAL_W-1:0]    mirror_arrival [NSLOT];
  logic [VAL_W-1:0]    mirror_remaining [NSLOT];
  logic [VAL_W-1:0]    mirror_burst [NSLOT];
  logic [NSLOT-1:0]    mirror_pending;
  logic [TIME_W-1:0]   mirror_time;
  logic [TIME_W-1:0]   mirror_idle_cnt;
  logic [SUM_W-1:0]    mirror_ta_sum;
  logic [SUM_W-1:0]    mirror_wt_sum;

  sched_beat_t         predicted_beats [$];
  int                  beats_sent;
  int                  mismatch_count = 0;
  int                  ticks_ran;
  int                  ticks_idle;
  int                  completions;
  int                  stall_cycles = 0;
  bit                  no_gaps;

  srtn_process_scheduler u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_command           (in_command),
    .in_slot              (in_slot),
    .in_arrival_time      (in_arrival_time),
    .in_burst_time        (in_burst_time),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_current_time     (out_current_time),
    .out_running_slot     (out_running_slot),
    .out_idle             (out_idle),
    .out_finished_now     (out_finished_now),
    .out_all_done         (out_all_done),
    .out_idle_total       (out_idle_total),
    .out_total_turnaround (out_total_turnaround),
    .out_total_waiting    (out_total_waiting)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Apply one accepted beat to the mirror and queue the result it must produce
  task automatic predict_schedule(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                                  input logic [VAL_W-1:0] arr, input logic [VAL_W-1:0] burst);
    sched_beat_t       r;
    int                best;
    logic [TIME_W-1:0] ta;
    logic [TIME_W-1:0] wt;
    logic [SUM_W:0]    sum;
    r    = '0;
    best = -1;
    case (cmd)
      CMD_LOAD: begin
        mirror_arrival[slot]   = arr;
        mirror_remaining[slot] = burst;
        mirror_burst[slot]     = burst;
        mirror_pending[slot]   = (burst != '0);
      end
      CMD_CLEAR: begin
        mirror_pending  = '0;
        mirror_time     = '0;
        mirror_idle_cnt = '0;
        mirror_ta_sum   = '0;
        mirror_wt_sum   = '0;
      end
      CMD_TICK: begin
        if (mirror_pending != '0) begin
          // pick least remaining, then earliest arrival, then lowest slot
          for (int i = 0; i < NSLOT; i++) begin
            if (mirror_pending[i] && TIME_W'(mirror_arrival[i]) <= mirror_time) begin
              if (best < 0 || mirror_remaining[i] < mirror_remaining[best] ||
                  (mirror_remaining[i] == mirror_remaining[best] &&
                   mirror_arrival[i] < mirror_arrival[best]))
                best = i;
            end
          end
          if (mirror_time != TIME_MAX) mirror_time = mirror_time + 1'b1;
          if (best < 0) begin
            r.idle = 1'b1;
            ticks_idle++;
            if (mirror_idle_cnt != TIME_MAX) mirror_idle_cnt = mirror_idle_cnt + 1'b1;
          end else begin
            ticks_ran++;
            r.run_slot = SLOT_W'(best);
            mirror_remaining[best] = mirror_remaining[best] - 1'b1;
            if (mirror_remaining[best] == '0) begin
              completions++;
              r.fin = 1'b1;
              mirror_pending[best] = 1'b0;
              ta = mirror_time - TIME_W'(mirror_arrival[best]);
              wt = (ta >= TIME_W'(mirror_burst[best])) ?
                   ta - TIME_W'(mirror_burst[best]) : '0;
              sum = {1'b0, mirror_ta_sum} + (SUM_W + 1)'(ta);
              mirror_ta_sum = (sum > SUM_MAX) ? SUM_MAX : sum[SUM_W-1:0];
              sum = {1'b0, mirror_wt_sum} + (SUM_W + 1)'(wt);
              mirror_wt_sum = (sum > SUM_MAX) ? SUM_MAX : sum[SUM_W-1:0];
            end
          end
        end
      end
      default: ;
    endcase
    r.cur_time = mirror_time;
    r.done     = (mirror_pending == '0);
    r.idle_tot = mirror_idle_cnt;
    r.ta_tot   = mirror_ta_sum;
    r.wt_tot   = mirror_wt_sum;
    predicted_beats.push_back(r);
  endtask

  // Drive one beat at the falling edge, idling first at random, and hold it until accepted
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                           input logic [VAL_W-1:0] arr, input logic [VAL_W-1:0] burst);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_slot         <= slot;
    in_arrival_time <= arr;
    in_burst_time   <= burst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    predict_schedule(cmd, slot, arr, burst);
  endtask

  // Hold the sender until every predicted beat is back, then let the block settle
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_beats.size() != 0) @(posedge clk);
    repeat (NSLOT + 8) @(posedge clk);
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, SLOT_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
  endtask

  task automatic send_clear();
    send_item(CMD_CLEAR, SLOT_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
  endtask

  // Load a job that arrives near the current time with a short burst
  task automatic load_job();
    int a;
    int b;
    a = int'(mirror_time) - 5 + int'($urandom_range(30));
    if (a < 0) a = 0;
    if (a > 65535) a = 65535;
    b = ($urandom_range(99) < 4) ? 0 : int'($urandom_range(1, 12));
    send_item(CMD_LOAD, SLOT_W'($urandom), VAL_W'(a), VAL_W'(b));
  endtask

  // Any command with full-range fields
  task automatic send_noise();
    send_item(CMD_W'($urandom), SLOT_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
  endtask

  function automatic bit job_reachable();
    for (int i = 0; i < NSLOT; i++)
      if (mirror_pending[i] && TIME_W'(mirror_arrival[i]) <= mirror_time + REACH_AHEAD)
        return 1'b1;
    return 1'b0;
  endfunction

  // Empty ticks, ignored command, zero burst, far arrival, ties, overwrite and clear
  task automatic test_directed_cases();
    send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_UNUSED, '1, '1, '1);
    send_item(CMD_LOAD, 4'd0, 16'd0, 16'd0);
    send_item(CMD_TICK, '1, '1, '1);
    send_item(CMD_LOAD, 4'd15, 16'hFFFF, 16'hFFFF);
    send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_LOAD, 4'd3, 16'd1, 16'd3);
    send_item(CMD_LOAD, 4'd5, 16'd1, 16'd3);
    send_item(CMD_LOAD, 4'd9, 16'd0, 16'd4);
    send_item(CMD_LOAD, 4'd2, 16'd2, 16'd4);
    repeat (8) send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_LOAD, 4'd2, 16'd3, 16'd1);
    repeat (2) send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_CLEAR, '0, '0, '0);
    send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_LOAD, 4'd1, 16'd0, 16'd1);
    send_item(CMD_TICK, '0, '0, '0);
  endtask

  // Well-formed schedules with random jobs, interleaved loads and some noise
  task automatic test_random_schedules(input int n_items);
    int start;
    int ticks;
    int pick;
    start = beats_sent;
    while (beats_sent - start < n_items) begin
      if ($urandom_range(99) < 90) send_clear();
      repeat ($urandom_range(1, 8)) load_job();
      ticks = 0;
      while (job_reachable() && ticks < 150) begin
        pick = $urandom_range(99);
        if (pick < 6) load_job();
        else if (pick < 10) send_noise();
        else send_tick();
        ticks++;
      end
      send_tick();
      if ($urandom_range(99) < 4) drain_results();
    end
  endtask

  // Same traffic with neither side idling
  task automatic test_steady_stream(input int n_items);
    no_gaps = 1'b1;
    test_random_schedules(n_items);
    no_gaps = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [SUM_W-1:0] want,
                             input logic [SUM_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    sched_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_beats.size() == 0) begin
        $display("%0t ns: result beat with nothing predicted, expected none actual time %0d",
                 $time, out_current_time);
        mismatch_count++;
      end else begin
        want = predicted_beats.pop_front();
        check_field("current_time", want.cur_time, out_current_time);
        check_field("running_slot", want.run_slot, out_running_slot);
        check_field("idle", want.idle, out_idle);
        check_field("finished_now", want.fin, out_finished_now);
        check_field("all_done", want.done, out_all_done);
        check_field("idle_total", want.idle_tot, out_idle_total);
        check_field("total_turnaround", want.ta_tot, out_total_turnaround);
        check_field("total_waiting", want.wt_tot, out_total_waiting);
      end
    end
  end

  // Randomly stall the result side
  always @(negedge clk) begin
    out_ready <= no_gaps ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("%0t ns: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_command      = CMD_LOAD;
    in_slot         = '0;
    in_arrival_time = '0;
    in_burst_time   = '0;
    no_gaps         = 1'b0;
    beats_sent      = 0;
    ticks_ran       = 0;
    ticks_idle      = 0;
    completions     = 0;
    mirror_pending  = '0;
    mirror_time     = '0;
    mirror_idle_cnt = '0;
    mirror_ta_sum   = '0;
    mirror_wt_sum   = '0;
    for (int i = 0; i < NSLOT; i++) begin
      mirror_arrival[i]   = '0;
      mirror_remaining[i] = '0;
      mirror_burst[i]     = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    drain_results();
    test_random_schedules(650);
    test_steady_stream(200);
    test_random_schedules(280);
    drain_results();

    $display("Sent %0d beats: %0d ticks ran a slot, %0d idle ticks, %0d completions,",
             beats_sent, ticks_ran, ticks_idle, completions);
    $display("loads, clears, ignored commands and noise mixed in; %0d field mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ srtn_process_scheduler.f @@
rtl/srtn_pkg.sv
rtl/srtn_cell.sv
rtl/srtn_process_scheduler.sv
bench/srtn_process_scheduler_tb.sv
